### design/wsae_pkg.sv
package wsae_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_WINDOW = 8'd1;

    localparam logic [CFG_DATA_W-1:0] RESET_POSITION_WINDOW = 7'd35;
    localparam logic [CFG_DATA_W-1:0] RESET_VELOCITY_WINDOW = 7'd55;

    // Field widths
    localparam int POS_W = 32;
    localparam int RES_W = 16;

    // Result queue
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 2;

    typedef logic [RES_W-1:0] res_t;

    // Per-tick strobes shared by all lanes
    typedef struct packed {
        logic load;       // transaction accepted: write position, read both tails
        logic vel_write;  // stage 1 holds an item: store its speed
        logic fwd_hit;    // velocity tail was written on the load edge
    } lane_ctl_t;

endpackage

### design/wsae_index.sv
module wsae_index #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic [wsae_pkg::CFG_DATA_W-1:0]     position_window,
    input  logic [wsae_pkg::CFG_DATA_W-1:0]     velocity_window,
    output logic [$clog2(MAX_WINDOW)-1:0]       pos_wr_addr,
    output logic [$clog2(MAX_WINDOW)-1:0]       pos_rd_addr,
    output logic [$clog2(MAX_WINDOW)-1:0]       vel_rd_addr,
    output logic [$clog2(MAX_WINDOW)-1:0]       vel_wr_addr,
    output wsae_pkg::lane_ctl_t                 lane_ctl
);

    localparam int HW = $clog2(MAX_WINDOW);
    localparam int NW = HW + 1;
    localparam int CW = (NW > wsae_pkg::CFG_DATA_W) ? NW : wsae_pkg::CFG_DATA_W;

    function automatic logic [NW-1:0] clamp_window(
        input logic [wsae_pkg::CFG_DATA_W-1:0] w
    );
        logic [CW-1:0] wx;
        logic [CW-1:0] r;
        wx = CW'(w);
        if (wx < CW'(2)) begin
            r = CW'(2);
        end else if (wx > CW'(MAX_WINDOW)) begin
            r = CW'(MAX_WINDOW);
        end else begin
            r = wx;
        end
        return r[NW-1:0];
    endfunction

    // head+1, back to slot 0 at or past the window
    function automatic logic [HW-1:0] next_slot(
        input logic [HW-1:0] idx,
        input logic [NW-1:0] w
    );
        logic [NW-1:0] n;
        n = {1'b0, idx} + NW'(1);
        return (n >= w) ? '0 : n[HW-1:0];
    endfunction

    logic [HW-1:0] ph_reg, ph_next;
    logic [HW-1:0] vh_reg, vh_next;
    logic [HW-1:0] vh_s1_reg, vh_s1_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          fwd_hit_reg, fwd_hit_next;

    logic [NW-1:0] pw;
    logic [NW-1:0] vw;
    logic [HW-1:0] pt;
    logic [HW-1:0] vt;

    always_comb begin
        pw = clamp_window(position_window);
        vw = clamp_window(velocity_window);
        pt = next_slot(ph_reg, pw);
        vt = next_slot(vh_reg, vw);
    end

    always_comb begin
        ph_next       = load ? pt : ph_reg;
        vh_next       = load ? vt : vh_reg;
        vh_s1_next    = load ? vh_reg : vh_s1_reg;
        s1_valid_next = load;
        // item ahead stores its speed on the same edge this tail is read
        fwd_hit_next  = load && s1_valid_reg && (vh_s1_reg == vt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg       <= '0;
            vh_reg       <= '0;
            vh_s1_reg    <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            ph_reg       <= ph_next;
            vh_reg       <= vh_next;
            vh_s1_reg    <= vh_s1_next;
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    assign pos_wr_addr        = ph_reg;
    assign pos_rd_addr        = pt;
    assign vel_rd_addr        = vt;
    assign vel_wr_addr        = vh_s1_reg;
    assign lane_ctl.load      = load;
    assign lane_ctl.vel_write = s1_valid_reg;
    assign lane_ctl.fwd_hit   = fwd_hit_reg;

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(ph_reg) < NW'(MAX_WINDOW)) && (NW'(vh_reg) < NW'(MAX_WINDOW)))
        else $error("ring head beyond MAX_WINDOW");

    a_fwd_needs_prior: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg && $past(s1_valid_reg))
        else $error("forward hit without a preceding item in stage 1");

endmodule

### design/wsae_lane.sv
module wsae_lane #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wsae_pkg::lane_ctl_t             lane_ctl,
    input  logic [$clog2(MAX_WINDOW)-1:0]   pos_wr_addr,
    input  logic [$clog2(MAX_WINDOW)-1:0]   pos_rd_addr,
    input  logic [$clog2(MAX_WINDOW)-1:0]   vel_rd_addr,
    input  logic [$clog2(MAX_WINDOW)-1:0]   vel_wr_addr,
    input  wsae_pkg::res_t                  position_lo,
    output wsae_pkg::res_t                  speed,
    output wsae_pkg::res_t                  accel
);

    // Low 16 bits of each difference depend only on low 16 bits of the
    // operands, so both rings hold 16-bit words.
    wsae_pkg::res_t pos_mem [MAX_WINDOW];
    wsae_pkg::res_t vel_mem [MAX_WINDOW];

    logic [MAX_WINDOW-1:0] pos_vld_reg;
    logic [MAX_WINDOW-1:0] vel_vld_reg;

    wsae_pkg::res_t pos_s1_reg;
    wsae_pkg::res_t pos_tail_reg;
    wsae_pkg::res_t vel_tail_reg;
    wsae_pkg::res_t spd_prev_reg;
    logic           pos_tail_vld_reg;
    logic           vel_tail_vld_reg;

    wsae_pkg::res_t pos_tail;
    wsae_pkg::res_t vel_tail;

    always_ff @(posedge aclk) begin
        if (lane_ctl.load) begin
            pos_mem[pos_wr_addr] <= position_lo;
            pos_tail_reg         <= pos_mem[pos_rd_addr];
            vel_tail_reg         <= vel_mem[vel_rd_addr];
            pos_s1_reg           <= position_lo;
            spd_prev_reg         <= speed;
        end
        if (lane_ctl.vel_write) begin
            vel_mem[vel_wr_addr] <= speed;
        end
    end

    // Slots never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_vld_reg      <= '0;
            vel_vld_reg      <= '0;
            pos_tail_vld_reg <= 1'b0;
            vel_tail_vld_reg <= 1'b0;
        end else begin
            if (lane_ctl.load) begin
                pos_vld_reg[pos_wr_addr] <= 1'b1;
                pos_tail_vld_reg         <= pos_vld_reg[pos_rd_addr];
                vel_tail_vld_reg         <= vel_vld_reg[vel_rd_addr];
            end
            if (lane_ctl.vel_write) begin
                vel_vld_reg[vel_wr_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        pos_tail = pos_tail_vld_reg ? pos_tail_reg : '0;
        if (lane_ctl.fwd_hit) begin
            vel_tail = spd_prev_reg;
        end else begin
            vel_tail = vel_tail_vld_reg ? vel_tail_reg : '0;
        end
        speed = pos_s1_reg - pos_tail;
        accel = speed - vel_tail;
    end

endmodule

### design/wsae_outq.sv
module wsae_outq #(
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data,
    output logic              can_accept
);

    localparam logic [wsae_pkg::OUTQ_PTR_W-1:0] LAST_PTR =
        wsae_pkg::OUTQ_PTR_W'(wsae_pkg::OUTQ_DEPTH - 1);
    localparam logic [wsae_pkg::OUTQ_CNT_W:0] DEPTH_X =
        (wsae_pkg::OUTQ_CNT_W + 1)'(wsae_pkg::OUTQ_DEPTH);

    logic [DATA_W-1:0] slot_reg [wsae_pkg::OUTQ_DEPTH];

    logic [wsae_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wsae_pkg::OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wsae_pkg::OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                            do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid  = (count_reg != '0);
    assign out_data   = slot_reg[rd_ptr_reg];
    // room for one more item behind the one in stage 1
    assign can_accept = ({1'b0, count_reg} + {{wsae_pkg::OUTQ_CNT_W{1'b0}}, push}) < DEPTH_X;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !do_pop && ({1'b0, count_reg} == DEPTH_X)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> (count_reg != '0))
        else $error("result queue lost an item");

endmodule

### design/windowed_speed_accel_estimator.sv
// Windowed speed / acceleration estimator, one lane per joint.
// Input stream (s_axis_*): one transaction per control tick carrying one
// 32-bit position per joint. Output stream (m_axis_*): one transaction per
// input with speed and acceleration (low 16 bits) for every joint.
// Config channel (cfg_*): index 0 = position window, index 1 = velocity
// window; cfg_ready is always high. Write only while the block is idle.
// Throughput: one transaction per cycle while s_axis_tready is high; the
// ring read and write of a tick fall on different ports of each lane's
// ring, and a speed that the next tick needs as its velocity tail is
// forwarded around the ring. From acceptance, stage 1 registers the ring
// reads, then the result queue register drives m_axis_tvalid.
// Stall: a 3-entry result queue sits behind stage 1; s_axis_tready drops
// only when the queue plus the item in flight would fill it, so the input
// keeps flowing while a finished result waits on m_axis_tready.
// Reset (aresetn low, synchronous): heads return to slot 0, windows to
// 35 and 55, ring valid bits clear so all slots read as zero, the queue
// empties. No clearing pass is needed.
module windowed_speed_accel_estimator #(
    parameter int MAX_WINDOW = 64,
    parameter int JOINTS     = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // joint j position at [32*j +: 32]: position_a, position_b, ...
    input  logic [wsae_pkg::POS_W*JOINTS-1:0]   s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,

    // per joint from the bottom: speed_a, accel_a, speed_b, accel_b, ...
    output logic [2*wsae_pkg::RES_W*JOINTS-1:0] m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wsae_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HW     = $clog2(MAX_WINDOW);
    localparam int OUT_W  = 2 * wsae_pkg::RES_W * JOINTS;

    logic [wsae_pkg::CFG_DATA_W-1:0] pos_win_reg, pos_win_next;
    logic [wsae_pkg::CFG_DATA_W-1:0] vel_win_reg, vel_win_next;

    logic                load;
    logic [HW-1:0]       pos_wr_addr;
    logic [HW-1:0]       pos_rd_addr;
    logic [HW-1:0]       vel_rd_addr;
    logic [HW-1:0]       vel_wr_addr;
    wsae_pkg::lane_ctl_t lane_ctl;
    logic [OUT_W-1:0]    stage1_data;
    logic                can_accept;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        pos_win_next = pos_win_reg;
        vel_win_next = vel_win_reg;
        if (cfg_valid) begin
            case (cfg_index)
                wsae_pkg::REG_POSITION_WINDOW: pos_win_next = cfg_data;
                wsae_pkg::REG_VELOCITY_WINDOW: vel_win_next = cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_win_reg <= wsae_pkg::RESET_POSITION_WINDOW;
            vel_win_reg <= wsae_pkg::RESET_VELOCITY_WINDOW;
        end else begin
            pos_win_reg <= pos_win_next;
            vel_win_reg <= vel_win_next;
        end
    end

    // ---------------------------------------------------------------
    // Head / tail indices, shared by all lanes
    // ---------------------------------------------------------------
    assign load = s_axis_tvalid && s_axis_tready;

    wsae_index #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_index (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .position_window (pos_win_reg),
        .velocity_window (vel_win_reg),
        .pos_wr_addr     (pos_wr_addr),
        .pos_rd_addr     (pos_rd_addr),
        .vel_rd_addr     (vel_rd_addr),
        .vel_wr_addr     (vel_wr_addr),
        .lane_ctl        (lane_ctl)
    );

    // ---------------------------------------------------------------
    // One lane per joint. Only the low half of each position matters
    // for the truncated results.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < JOINTS; j++) begin : g_lane
        wsae_pkg::res_t speed_j;
        wsae_pkg::res_t accel_j;

        wsae_lane #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .lane_ctl    (lane_ctl),
            .pos_wr_addr (pos_wr_addr),
            .pos_rd_addr (pos_rd_addr),
            .vel_rd_addr (vel_rd_addr),
            .vel_wr_addr (vel_wr_addr),
            .position_lo (s_axis_tdata[wsae_pkg::POS_W*j +: wsae_pkg::RES_W]),
            .speed       (speed_j),
            .accel       (accel_j)
        );

        // merge: speed then accel for each joint
        assign stage1_data[2*wsae_pkg::RES_W*j +: wsae_pkg::RES_W] = speed_j;
        assign stage1_data[2*wsae_pkg::RES_W*j + wsae_pkg::RES_W +: wsae_pkg::RES_W] =
            accel_j;
    end

    // ---------------------------------------------------------------
    // Result queue; decouples the input side from output stalls
    // ---------------------------------------------------------------
    wsae_outq #(
        .DATA_W (OUT_W)
    ) u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (lane_ctl.vel_write),
        .push_data  (stage1_data),
        .pop        (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .can_accept (can_accept)
    );

    assign s_axis_tready = can_accept;

endmodule

### tb/windowed_speed_accel_estimator_test.sv
module windowed_speed_accel_estimator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN     = 64;
    localparam int JOINTS      = 2;
    localparam int LONG_HOLD   = 100;    // cycles the sink refuses results once
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;      // outlasts the input-to-output path, catches stray results

    typedef logic [wsae_pkg::POS_W-1:0]      pos_t;
    typedef logic [wsae_pkg::CFG_DATA_W-1:0] window_t;

    // One result transaction, first field in the lowest bits
    typedef struct packed {
        wsae_pkg::res_t accel_b;
        wsae_pkg::res_t speed_b;
        wsae_pkg::res_t accel_a;
        wsae_pkg::res_t speed_a;
    } motion_t;

    typedef enum {STEP_TICK, STEP_WINDOWS} step_kind_t;
    typedef enum {STYLE_SMOOTH, STYLE_NOISE, STYLE_EXTREME} motion_style_t;

    typedef struct {
        step_kind_t kind;
        window_t    pos_win;
        window_t    vel_win;
        pos_t       pa;
        pos_t       pb;
        bit         known;      // want[] typed in by hand
        motion_t    want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                                aclk          = 1'b0;
    logic                                aresetn       = 1'b0;
    logic [wsae_pkg::POS_W*JOINTS-1:0]   s_axis_tdata  = '0;   // position_a, position_b
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [2*wsae_pkg::RES_W*JOINTS-1:0] m_axis_tdata;   // speed_a, accel_a, speed_b, accel_b
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [wsae_pkg::CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [wsae_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

    windowed_speed_accel_estimator #(
        .MAX_WINDOW (MAX_WIN),
        .JOINTS     (JOINTS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of both rings, heads and window registers
    // ------------------------------------------------------------------
    pos_t    pos_hist [MAX_WIN][JOINTS];
    pos_t    spd_hist [MAX_WIN][JOINTS];
    int unsigned pos_head = 0;
    int unsigned spd_head = 0;
    window_t pos_win = wsae_pkg::RESET_POSITION_WINDOW;
    window_t vel_win = wsae_pkg::RESET_VELOCITY_WINDOW;

    motion_t expected_motion [$];   // one entry per accepted tick, oldest first

    // Run bookkeeping
    int      mismatches    = 0;
    int      ticks_sent    = 0;
    int      results_seen  = 0;
    int      window_writes = 0;
    int      input_stalls  = 0;
    int      cycle_count   = 0;

    // Idling control, written by the stimulus process
    int      send_idle_pct = 0;
    int      rx_idle_pct   = 0;
    int      hold_requests = 0;
    int      hold_served   = 0;
    int      rx_wait       = 0;

    // Smooth trajectory generator state
    pos_t    track [JOINTS];
    int      rate  [JOINTS];

    stim_row_t directed_rows [$];

    motion_t seen_motion;
    motion_t due_motion;

    // Out-of-range window values behave as the nearest legal size
    function automatic int unsigned eff_window(input window_t w);
        if (w < 2)
            return 2;
        if (w > MAX_WIN)
            return MAX_WIN;
        return w;
    endfunction

    // Index past the window (possible after a shrink) wraps to slot 0
    function automatic int unsigned wrap_next(input int unsigned idx, input int unsigned w);
        return (idx + 1 >= w) ? 0 : idx + 1;
    endfunction

    // Speed/accel of one tick; updates rings and heads as the block does
    function automatic motion_t estimate_motion(input pos_t pa, input pos_t pb);
        int unsigned pw, vw, ph, vh, pt, vt;
        pos_t        sample [JOINTS];
        pos_t        spd, acc;
        motion_t     r;
        int          j;
        pw = eff_window(pos_win);
        vw = eff_window(vel_win);
        ph = (pos_head >= MAX_WIN) ? 0 : pos_head;
        vh = (spd_head >= MAX_WIN) ? 0 : spd_head;
        pt = wrap_next(ph, pw);     // oldest position slot
        vt = wrap_next(vh, vw);     // oldest speed slot
        sample[0] = pa;
        sample[1] = pb;
        r = '0;
        for (j = 0; j < JOINTS; j++) begin
            pos_hist[ph][j] = sample[j];
            spd = sample[j] - pos_hist[pt][j];     // wraps at 32 bits
            spd_hist[vh][j] = spd;
            acc = spd - spd_hist[vt][j];
            if (j == 0) begin
                r.speed_a = spd[wsae_pkg::RES_W-1:0];
                r.accel_a = acc[wsae_pkg::RES_W-1:0];
            end else begin
                r.speed_b = spd[wsae_pkg::RES_W-1:0];
                r.accel_b = acc[wsae_pkg::RES_W-1:0];
            end
        end
        pos_head = wrap_next(ph, pw);
        spd_head = wrap_next(vh, vw);
        return r;
    endfunction

    function automatic void check_field(input string name, input wsae_pkg::res_t want,
                                        input wsae_pkg::res_t got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: result %0d %s expected %h actual %h",
                     $time, results_seen, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick and hold it until the block takes the transaction
    task automatic offer(input pos_t pa, input pos_t pb, input bit known, input motion_t want);
        motion_t predicted;
        s_axis_tdata  <= {pb, pa};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        predicted = estimate_motion(pa, pb);
        expected_motion.push_back(known ? want : predicted);
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_motion.size() != 0)
            @(posedge aclk);
    endtask

    // Both registers, back to back, only while the block is idle
    task automatic set_windows(input window_t pw, input window_t vw);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= wsae_pkg::REG_POSITION_WINDOW;
        cfg_data  <= pw;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        pos_win = pw;
        cfg_index <= wsae_pkg::REG_VELOCITY_WINDOW;
        cfg_data  <= vw;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        vel_win = vw;
        cfg_valid <= 1'b0;
        window_writes += 2;
    endtask

    function automatic window_t pick_window();
        case ($urandom_range(0, 9))
            0: return window_t'(0);
            1: return window_t'(1);
            2: return window_t'(2);
            3: return window_t'(3);
            4: return window_t'(MAX_WIN);
            5: return window_t'(MAX_WIN + 1);
            6: return window_t'(127);
            7: return window_t'($urandom_range(0, 127));
            default: return window_t'($urandom_range(2, MAX_WIN));
        endcase
    endfunction

    // Mostly smooth joint motion; noise and extremes mixed in
    function automatic pos_t next_position(input motion_style_t style, input int j);
        case (style)
            STYLE_NOISE: begin
                return pos_t'($urandom);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    default: return pos_t'($urandom);
                endcase
            end
            default: begin
                rate[j] = rate[j] + $urandom_range(0, 128) - 64;
                if (rate[j] > 3000)
                    rate[j] = 3000;
                if (rate[j] < -3000)
                    rate[j] = -3000;
                // occasionally jump next to the signed wrap point
                if ($urandom_range(0, 49) == 0)
                    track[j] = 32'h7FFF_F000 + $urandom_range(0, 8191);
                track[j] = track[j] + pos_t'(rate[j]);
                if ($urandom_range(0, 19) == 0)
                    return pos_t'($urandom);     // glitch sample
                return track[j];
            end
        endcase
    endfunction

    task automatic run_ticks(input int count, input motion_style_t style);
        pos_t pa, pb;
        int   i;
        for (i = 0; i < count; i++) begin
            pa = next_position(style, 0);
            pb = next_position(style, 1);
            offer(pa, pb, 1'b0, '0);
            if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    endtask

    // Directed table helpers
    function automatic void add_windows(input window_t pw, input window_t vw);
        stim_row_t row;
        row = '{kind: STEP_WINDOWS, pos_win: pw, vel_win: vw, pa: '0, pb: '0,
                known: 1'b0, want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(input pos_t pa, input pos_t pb);
        stim_row_t row;
        row = '{kind: STEP_TICK, pos_win: '0, vel_win: '0, pa: pa, pb: pb,
                known: 1'b0, want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(input pos_t pa, input pos_t pb,
                                      input wsae_pkg::res_t sa, input wsae_pkg::res_t aa,
                                      input wsae_pkg::res_t sb, input wsae_pkg::res_t ab);
        stim_row_t row;
        row = '{kind: STEP_TICK, pos_win: '0, vel_win: '0, pa: pa, pb: pb,
                known: 1'b1, want: '0};
        row.want.speed_a = sa;
        row.want.accel_a = aa;
        row.want.speed_b = sb;
        row.want.accel_b = ab;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            rx_wait       <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_wait       <= $urandom_range(0, 9);     // random stall burst
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (m_axis_tvalid && m_axis_tready) begin
                seen_motion = motion_t'(m_axis_tdata);
                if (expected_motion.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, seen_motion);
                end else begin
                    due_motion = expected_motion.pop_front();
                    check_field("speed_a", due_motion.speed_a, seen_motion.speed_a);
                    check_field("accel_a", due_motion.accel_a, seen_motion.accel_a);
                    check_field("speed_b", due_motion.speed_b, seen_motion.speed_b);
                    check_field("accel_b", due_motion.accel_b, seen_motion.accel_b);
                end
                results_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding",
                     $time, expected_motion.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        stim_row_t row;
        int        phase;
        int        r;

        // rings start cleared, as after reset
        foreach (pos_hist[i, j]) begin
            pos_hist[i][j] = '0;
            spd_hist[i][j] = '0;
        end

        for (r = 0; r < JOINTS; r++) begin
            track[r] = pos_t'($urandom);
            rate[r]  = 0;
        end

        // Reset windows (35/55) and empty rings: every tail reads zero for
        // the first ticks, so speed = low half of the sample, accel = speed.
        add_known(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        add_known(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
        add_known(32'h0000_8000, 32'hFFFF_7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        add_known(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_known(32'h1234_5678, 32'hDEAD_BEEF, 16'h5678, 16'h5678, 16'hBEEF, 16'hBEEF);
        // Below range, and heads now sit beyond the shrunken windows
        add_windows(window_t'(0), window_t'(1));
        add_tick(32'h8000_0000, 32'h7FFF_FFFF);     // signed wrap both ways
        add_tick(32'h7FFF_FFFF, 32'h8000_0000);
        add_tick(32'h0001_0000, 32'hFFFF_0000);     // low half zero, high half not
        add_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Above range on both
        add_windows(window_t'(127), window_t'(MAX_WIN + 1));
        add_tick(32'h0000_0100, 32'hFFFF_FF00);
        add_tick(32'h0000_0200, 32'hFFFF_FE00);
        add_tick(32'h7FFF_0000, 32'h8000_FFFF);
        add_tick(32'h8001_0000, 32'h7FFE_FFFF);
        // Largest and smallest legal, mixed
        add_windows(window_t'(MAX_WIN), window_t'(2));
        add_tick(32'h0000_0000, 32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFF, 32'h0000_0000);
        add_tick(32'h5555_5555, 32'hAAAA_AAAA);
        add_windows(window_t'(2), window_t'(MAX_WIN));
        add_tick(32'hAAAA_AAAA, 32'h5555_5555);
        add_tick(32'h8000_0000, 32'h8000_0000);
        add_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_windows(window_t'(40), window_t'(3));
        add_tick(32'h0000_7FFF, 32'hFFFF_8000);
        add_tick(32'hFFFF_8000, 32'h0000_7FFF);
        add_tick(32'h0F0F_0F0F, 32'hF0F0_F0F0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, back to back
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == STEP_WINDOWS)
                set_windows(row.pos_win, row.vel_win);
            else
                offer(row.pa, row.pb, row.known, row.want);
        end

        // Random part: ten phases, each under its own window setting
        for (phase = 0; phase < 10; phase++) begin
            set_windows(pick_window(), pick_window());
            if (phase == 9) begin
                // last stretch runs with no idling at all
                send_idle_pct = 0;
                rx_idle_pct  <= 0;
            end else begin
                send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                rx_idle_pct  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            end

            case (phase)
                2: begin
                    // sink holds off while the source keeps pushing: the
                    // result queue fills and s_axis_tready must drop
                    send_idle_pct  = 0;
                    hold_requests <= hold_requests + 1;
                    run_ticks(40, STYLE_SMOOTH);
                    run_ticks(98, STYLE_NOISE);
                end
                4: begin
                    // source pauses until the block has emptied
                    run_ticks(60, STYLE_SMOOTH);
                    drain();
                    run_ticks(78, STYLE_EXTREME);
                end
                default: begin
                    run_ticks(138, motion_style_t'(phase % 3));
                end
            endcase
        end

        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("Run: %0d ticks, %0d results, %0d window writes (0..127 incl. clamps),",
                 ticks_sent, results_seen, window_writes);
        $display("     %0d stalled input cycles, %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0 && expected_motion.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
